FILE: hdl/rmu_pkg.sv
// Package for the recursive mutex unit: sizes, opcode and status codes,
// and the control and status structs between the top level and the queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rmu_pkg;

  // Number of entries in the waiter queue.
  localparam int WAIT_DEPTH = 16;
  // Number of significant bits in a task number.
  localparam int TASK_BITS = 8;

  // Width of the task_id field on the ports.
  localparam int TASK_ID_W = 8;
  // Bits of a task number that survive masking.
  localparam int TASK_W = (TASK_BITS < TASK_ID_W) ? TASK_BITS : TASK_ID_W;
  // Queue pointer and fill count widths.
  localparam int PTR_W = $clog2(WAIT_DEPTH);
  localparam int CNT_W = $clog2(WAIT_DEPTH + 1);
  // Recursion depth width and its saturation value.
  localparam int DEPTH_W = 8;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  typedef logic [TASK_W-1:0] task_t;

  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_HOLDER = 3'd1,
    ST_QUEUE_FULL = 3'd2,
    ST_DEPTH_SAT  = 3'd3,
    ST_IGNORED    = 3'd4
  } status_t;

  // Requests from the lock logic to the waiter queue.
  typedef struct packed {
    logic  push;
    logic  pop;
    task_t push_task;
  } q_ctl_t;

  // What the waiter queue reports back.
  typedef struct packed {
    logic  empty;
    logic  full;
    task_t front;
  } q_stat_t;

endpackage : rmu_pkg

`default_nettype wire

FILE: hdl/rmu_req_if.sv
// Request channel of the recursive mutex unit: valid, ready and the
// opcode and task number of one request. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface rmu_req_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] task_id;

  modport source (output valid, output opcode, output task_id, input ready);
  modport sink   (input valid, input opcode, input task_id, output ready);
endinterface : rmu_req_if

`default_nettype wire

FILE: hdl/rmu_rsp_if.sv
// Response channel of the recursive mutex unit: valid, ready and the
// fields of one result. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface rmu_rsp_if;
  logic       valid;
  logic       ready;
  logic       granted;
  logic       must_wait;
  logic       wake_valid;
  logic [7:0] wake_task;
  logic [7:0] depth_now;
  logic [2:0] status;

  modport source (output valid, output granted, output must_wait, output wake_valid,
                  output wake_task, output depth_now, output status, input ready);
  modport sink   (input valid, input granted, input must_wait, input wake_valid,
                  input wake_task, input depth_now, input status, output ready);
endinterface : rmu_rsp_if

`default_nettype wire

FILE: hdl/recursive_mutex_unit_top.sv
// Top level of the recursive mutex unit: input register, lock logic,
// result register. Depends on rmu_pkg, rmu_req_if, rmu_rsp_if, rmu_wait_q.
//
//   Channel  Role   Carries
//   req      sink   opcode, task_id
//   rsp      source granted, must_wait, wake_valid, wake_task, depth_now, status
//
// A request passes from the input register to the result register, from which
// its result transfers; one request per cycle is sustained while rsp.ready
// stays high. The lock state and queue update in the same cycle.
// Reset frees the lock and empties the queue; queue slots are not cleared.
// A stalled result holds the input register, and req.ready drops only then.
`timescale 1ns / 1ps
`default_nettype none

module recursive_mutex_unit_top (
  input wire logic clk,
  input wire logic rst,
  rmu_req_if.sink   req,
  rmu_rsp_if.source rsp
);

  import rmu_pkg::*;

  // Input register.
  logic  in_vld;
  logic  in_op;
  task_t in_task;
  logic  adv;

  // Lock state.
  task_t             owner;
  task_t             owner_next;
  logic [DEPTH_W-1:0] hold_depth;
  logic [DEPTH_W-1:0] hold_depth_next;
  logic              lock_free;
  logic              lock_free_next;

  // Result fields computed this cycle.
  logic    r_granted;
  logic    r_must_wait;
  logic    r_wake_valid;
  task_t   r_wake_task;
  status_t r_status;

  // Result register.
  logic               out_vld;
  logic               out_granted;
  logic               out_must_wait;
  logic               out_wake_valid;
  task_t              out_wake_task;
  logic [DEPTH_W-1:0] out_depth;
  status_t            out_status;

  q_ctl_t  q_ctl;
  q_stat_t q_stat;

  // The request in the input register moves on when the result slot is free.
  assign adv       = in_vld && (!out_vld || rsp.ready);
  assign req.ready = !in_vld || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (req.ready) begin
      in_vld <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_op   <= req.opcode;
      in_task <= req.task_id[TASK_W-1:0];
    end
  end

  rmu_wait_q u_wait_q (
    .clk  (clk),
    .rst  (rst),
    .ctl  (q_ctl),
    .stat (q_stat)
  );

  // Lock logic for the request in the input register.
  always_comb begin
    owner_next      = owner;
    hold_depth_next = hold_depth;
    lock_free_next  = lock_free;
    r_granted       = 1'b0;
    r_must_wait     = 1'b0;
    r_wake_valid    = 1'b0;
    r_wake_task     = '0;
    r_status        = ST_OK;
    q_ctl.push      = 1'b0;
    q_ctl.pop       = 1'b0;
    q_ctl.push_task = in_task;

    if (in_task == '0) begin
      r_status = ST_IGNORED;
    end else if (in_op == OP_ACQUIRE) begin
      priority if (!lock_free && owner == in_task) begin
        r_granted = 1'b1;
        if (hold_depth == DEPTH_MAX) begin
          r_status = ST_DEPTH_SAT;
        end else begin
          hold_depth_next = hold_depth + 1'b1;
        end
      end else if (lock_free) begin
        lock_free_next  = 1'b0;
        owner_next      = in_task;
        hold_depth_next = DEPTH_W'(1);
        r_granted       = 1'b1;
      end else if (q_stat.full) begin
        r_status = ST_QUEUE_FULL;
      end else begin
        q_ctl.push  = adv;
        r_must_wait = 1'b1;
      end
    end else begin
      priority if (lock_free || owner != in_task) begin
        r_status = ST_NOT_HOLDER;
      end else if (hold_depth > DEPTH_W'(1)) begin
        hold_depth_next = hold_depth - 1'b1;
      end else begin
        // Last release: free the lock and wake the front waiter.
        lock_free_next  = 1'b1;
        owner_next      = '0;
        hold_depth_next = '0;
        if (!q_stat.empty) begin
          q_ctl.pop    = adv;
          r_wake_valid = 1'b1;
          r_wake_task  = q_stat.front;
        end
      end
    end
  end

  // Lock state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      owner      <= '0;
      hold_depth <= '0;
      lock_free  <= 1'b1;
    end else if (adv) begin
      owner      <= owner_next;
      hold_depth <= hold_depth_next;
      lock_free  <= lock_free_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= 1'b1;
    end else if (rsp.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_granted    <= r_granted;
      out_must_wait  <= r_must_wait;
      out_wake_valid <= r_wake_valid;
      out_wake_task  <= r_wake_task;
      out_depth      <= hold_depth_next;
      out_status     <= r_status;
    end
  end

  // Response outputs.
  assign rsp.valid      = out_vld;
  assign rsp.granted    = out_granted;
  assign rsp.must_wait  = out_must_wait;
  assign rsp.wake_valid = out_wake_valid;
  assign rsp.wake_task  = TASK_ID_W'(out_wake_task);
  assign rsp.depth_now  = out_depth;
  assign rsp.status     = out_status;

endmodule : recursive_mutex_unit_top

`default_nettype wire

FILE: hdl/rmu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rmu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; a read of the address being
  // written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : rmu_ram

`default_nettype wire

FILE: hdl/rmu_wait_q.sv
// Circular queue of waiting tasks for the recursive mutex unit.
// Depends on rmu_pkg and rmu_ram.
`timescale 1ns / 1ps
`default_nettype none

module rmu_wait_q (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire rmu_pkg::q_ctl_t  ctl,
  output rmu_pkg::q_stat_t      stat
);

  import rmu_pkg::*;

  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] head_next;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic             fwd;
  task_t            fwd_task;
  task_t            ram_rdata;

  // Pointer after the given slot, wrapping at the queue depth.
  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] slot);
    return (slot == PTR_W'(WAIT_DEPTH - 1)) ? '0 : slot + 1'b1;
  endfunction

  // The read port always looks at the head as it stands after this cycle.
  always_comb begin
    head_next = ctl.pop ? next_slot(head) : head;
  end

  rmu_ram #(
    .WIDTH (TASK_W),
    .DEPTH (WAIT_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.push),
    .waddr (tail),
    .wdata (ctl.push_task),
    .raddr (head_next),
    .rdata (ram_rdata)
  );

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      fwd   <= 1'b0;
    end else begin
      head <= head_next;
      if (ctl.push) begin
        tail <= next_slot(tail);
      end
      if (ctl.push && !ctl.pop) begin
        count <= count + 1'b1;
      end else if (ctl.pop && !ctl.push) begin
        count <= count - 1'b1;
      end
      // A push into an empty queue lands on the slot being read.
      fwd <= ctl.push && (tail == head_next);
    end
  end

  always_ff @(posedge clk) begin
    fwd_task <= ctl.push_task;
  end

  // Queue status for the lock logic.
  always_comb begin
    stat.empty = (count == '0);
    stat.full  = (count == CNT_W'(WAIT_DEPTH));
    stat.front = fwd ? fwd_task : ram_rdata;
  end

endmodule : rmu_wait_q

`default_nettype wire

FILE: test/rmu_lock_checker.sv
// Checker for the recursive mutex unit: watches both channels, predicts each
// result from its own copy of the lock and waiter queue, and compares.
// Depends on rmu_pkg, rmu_req_if and rmu_rsp_if.
`timescale 1ns / 1ps

module rmu_lock_checker
  import rmu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  rmu_req_if   req,
  rmu_rsp_if   rsp,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic               granted;
    logic               must_wait;
    logic               wake_valid;
    logic [7:0]         wake_task;
    logic [DEPTH_W-1:0] depth_now;
    status_t            status;
  } lock_result_t;

  // Predicted lock state.
  task_t              lk_owner;
  logic [DEPTH_W-1:0] lk_depth;
  logic               lk_free;
  task_t              lk_slots [WAIT_DEPTH];
  int                 lk_head;
  int                 lk_tail;
  int                 lk_count;

  lock_result_t result_queue[$];
  int           mismatches = 0;

  // Applies one request to the predicted state and returns its result.
  function automatic lock_result_t predict_request(opcode_t op,
                                                   logic [TASK_ID_W-1:0] raw_id);
    lock_result_t r;
    task_t        id;
    id = raw_id[TASK_W-1:0];
    r = '0;
    r.status = ST_OK;
    if (id == '0) begin
      r.status = ST_IGNORED;
    end else if (op == OP_ACQUIRE) begin
      if (!lk_free && lk_owner == id) begin
        // The holder goes one level deeper, up to the saturation value.
        r.granted = 1'b1;
        if (lk_depth == DEPTH_MAX) r.status = ST_DEPTH_SAT;
        else lk_depth = lk_depth + 1'b1;
      end else if (lk_free) begin
        lk_free  = 1'b0;
        lk_owner = id;
        lk_depth = DEPTH_W'(1);
        r.granted = 1'b1;
      end else if (lk_count >= WAIT_DEPTH) begin
        r.status = ST_QUEUE_FULL;
      end else begin
        lk_slots[lk_tail] = id;
        lk_tail  = (lk_tail == WAIT_DEPTH - 1) ? 0 : lk_tail + 1;
        lk_count = lk_count + 1;
        r.must_wait = 1'b1;
      end
    end else begin
      if (lk_free || lk_owner != id) begin
        r.status = ST_NOT_HOLDER;
      end else if (lk_depth > 1) begin
        lk_depth = lk_depth - 1'b1;
      end else begin
        // Last release frees the lock and wakes the front waiter.
        lk_free  = 1'b1;
        lk_owner = '0;
        lk_depth = '0;
        if (lk_count > 0) begin
          r.wake_valid = 1'b1;
          r.wake_task  = 8'(lk_slots[lk_head]);
          lk_head  = (lk_head == WAIT_DEPTH - 1) ? 0 : lk_head + 1;
          lk_count = lk_count - 1;
        end
      end
    end
    r.depth_now = lk_depth;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare each result transfer, then predict each request transfer.
  always @(posedge clk) begin
    lock_result_t want;
    if (rst) begin
      lk_owner = '0;
      lk_depth = '0;
      lk_free  = 1'b1;
      lk_head  = 0;
      lk_tail  = 0;
      lk_count = 0;
      result_queue.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (result_queue.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d", $time,
                   rsp.status);
          mismatches++;
        end else begin
          want = result_queue.pop_front();
          check_field("granted", want.granted, rsp.granted);
          check_field("must_wait", want.must_wait, rsp.must_wait);
          check_field("wake_valid", want.wake_valid, rsp.wake_valid);
          check_field("wake_task", want.wake_task, rsp.wake_task);
          check_field("depth_now", want.depth_now, rsp.depth_now);
          check_field("status", want.status, rsp.status);
        end
      end
      if (req.valid && req.ready)
        result_queue.push_back(predict_request(opcode_t'(req.opcode), req.task_id));
    end
    fail_count <= mismatches;
    pending    <= result_queue.size();
  end

endmodule : rmu_lock_checker

FILE: test/tb_recursive_mutex_unit_top.sv
// Testbench top for the recursive mutex unit: clock, reset, request stimulus,
// result stall pattern, watchdog and verdict. Depends on rmu_pkg, the channel
// interfaces, recursive_mutex_unit_top and rmu_lock_checker.
`timescale 1ns / 1ps

module tb_recursive_mutex_unit_top;
  import rmu_pkg::*;

  localparam int RANDOM_ITEMS = 1600;
  localparam int IDLE_LIMIT   = 1000;

  typedef enum int {
    RX_ALWAYS,
    RX_MOSTLY,
    RX_RARELY,
    RX_RUNS
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   items_sent = 0;
  int   burst_left = 0;
  int   idle_cycles = 0;

  // Tasks the stimulus believes are queued, oldest first.
  logic [7:0] waiters[$];

  rmu_req_if req_ch ();
  rmu_rsp_if rsp_ch ();

  recursive_mutex_unit_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  rmu_lock_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #4 clk = ~clk;

  // Watchdog: end the run if nothing transfers for too long.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side stalls in phases of its own.
  initial begin : rsp_stall_pattern
    rx_mode_t mode;
    int       mode_left;
    int       run_left;
    logic     level;
    mode = RX_ALWAYS;
    mode_left = 0;
    run_left = 0;
    level = 1'b1;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(64, 256);
      end
      mode_left--;
      case (mode)
        RX_ALWAYS: rsp_ch.ready <= 1'b1;
        RX_MOSTLY: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_RARELY: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        default: begin
          if (run_left == 0) begin
            level = !level;
            run_left = level ? $urandom_range(1, 10) : $urandom_range(1, 20);
          end
          run_left--;
          rsp_ch.ready <= level;
        end
      endcase
    end
  end

  function automatic logic [7:0] pick_task();
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] pick_other(logic [7:0] busy);
    logic [7:0] id;
    do id = pick_task(); while (id == busy);
    return id;
  endfunction

  // One request transfer; the sender may pause between bursts.
  task automatic send_request(opcode_t op, logic [7:0] id);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    req_ch.valid   <= 1'b1;
    req_ch.opcode  <= op;
    req_ch.task_id <= id;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
  endtask

  // Occasional extra traffic while the lock is held.
  task automatic interleave(logic [7:0] holder);
    logic [7:0] id;
    int         pick;
    pick = $urandom_range(0, 9);
    if (pick <= 2) begin
      id = pick_other(holder);
      send_request(OP_ACQUIRE, id);
      if (waiters.size() < WAIT_DEPTH) waiters.push_back(id);
    end else if (pick == 3) begin
      send_request(opcode_t'($urandom_range(0, 1)), 8'd0);
    end else if (pick == 4) begin
      send_request(OP_RELEASE, pick_other(holder));
    end
  endtask

  // A woken waiter (or a fresh task) takes the lock, nests, and lets go.
  task automatic run_session();
    logic [7:0] holder;
    logic [7:0] woken;
    int         hold;
    if (waiters.size() != 0) begin
      woken = waiters.pop_front();
      if ($urandom_range(0, 3) == 0) begin
        // Another task grabs the free lock first; the woken one queues again.
        holder = pick_other(woken);
        send_request(OP_ACQUIRE, holder);
        send_request(OP_ACQUIRE, woken);
        waiters.push_back(woken);
      end else begin
        holder = woken;
        send_request(OP_ACQUIRE, holder);
      end
    end else begin
      holder = pick_task();
      send_request(OP_ACQUIRE, holder);
    end
    hold = $urandom_range(1, 4);
    for (int n = 1; n < hold; n++) begin
      send_request(OP_ACQUIRE, holder);
      interleave(holder);
    end
    interleave(holder);
    for (int n = 0; n < hold; n++) begin
      if (n < hold - 1) interleave(holder);
      send_request(OP_RELEASE, holder);
    end
    // Sometimes one release too many.
    if ($urandom_range(0, 5) == 0) send_request(OP_RELEASE, holder);
  endtask

  initial begin : stimulus
    logic [7:0] holder;
    logic [7:0] id;
    req_ch.valid   <= 1'b0;
    req_ch.opcode  <= OP_ACQUIRE;
    req_ch.task_id <= 8'd0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: ignored task, stray releases, nesting, repeat waiter,
    // a woken task losing the race, and a last release with an empty queue.
    send_request(OP_ACQUIRE, 8'd0);
    send_request(OP_RELEASE, 8'd0);
    send_request(OP_RELEASE, 8'd5);
    send_request(OP_ACQUIRE, 8'd255);
    send_request(OP_ACQUIRE, 8'd255);
    send_request(OP_ACQUIRE, 8'd1);
    send_request(OP_ACQUIRE, 8'd128);
    send_request(OP_ACQUIRE, 8'd1);
    send_request(OP_RELEASE, 8'd1);
    send_request(OP_RELEASE, 8'd0);
    send_request(OP_RELEASE, 8'd255);
    send_request(OP_RELEASE, 8'd255);
    send_request(OP_ACQUIRE, 8'd128);
    send_request(OP_ACQUIRE, 8'd1);
    send_request(OP_RELEASE, 8'd128);
    send_request(OP_ACQUIRE, 8'd128);
    send_request(OP_RELEASE, 8'd128);
    send_request(OP_ACQUIRE, 8'd1);
    send_request(OP_RELEASE, 8'd1);
    send_request(OP_ACQUIRE, 8'd1);
    send_request(OP_RELEASE, 8'd1);
    send_request(OP_ACQUIRE, 8'd0);

    // Nest past the depth limit and overfill the queue, then unwind.
    holder = pick_task();
    for (int n = 0; n < 258; n++) begin
      send_request(OP_ACQUIRE, holder);
      if (n >= 200 && n < 218) begin
        id = pick_other(holder);
        send_request(OP_ACQUIRE, id);
        if (waiters.size() < WAIT_DEPTH) waiters.push_back(id);
      end
    end
    for (int n = 0; n < 255; n++) send_request(OP_RELEASE, holder);

    // Random sessions drain the queue and keep the lock busy.
    while (items_sent < RANDOM_ITEMS) run_session();
    req_ch.valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (6) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule : tb_recursive_mutex_unit_top
